// File: src/cpll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpll_pkg: colormap lookup shared definitions
// Palette codes, node tables, result type and default sizes.
// ----------------------------------------------------------------------------
package cpll_pkg;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned ADDR_W      = 3;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned NODE_W      = 8;
  localparam int unsigned IDX_W       = 4;

  localparam logic REG_PALETTE_SEL = 1'b0;

  typedef enum logic [2:0] {
    PAL_VIRIDIS = 3'd0,
    PAL_PLASMA  = 3'd1,
    PAL_INFERNO = 3'd2,
    PAL_MAGMA   = 3'd3,
    PAL_TURBO   = 3'd4,
    PAL_CIVIDIS = 3'd5,
    PAL_GRAY    = 3'd6,
    PAL_RAINBOW = 3'd7
  } palette_e;

  typedef struct packed {
    logic [NODE_W-1:0] red;
    logic [NODE_W-1:0] green;
    logic [NODE_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t n0;
    rgb_t n1;
  } node_pair_t;

  localparam int unsigned PAIR_W = $bits(node_pair_t);

  function automatic logic [IDX_W-1:0] node_last(input palette_e pal);
    logic [IDX_W-1:0] last;
    unique case (pal)
      PAL_VIRIDIS: last = IDX_W'(10);
      PAL_PLASMA:  last = IDX_W'(9);
      PAL_INFERNO: last = IDX_W'(9);
      PAL_MAGMA:   last = IDX_W'(9);
      PAL_TURBO:   last = IDX_W'(8);
      PAL_CIVIDIS: last = IDX_W'(8);
      PAL_GRAY:    last = IDX_W'(1);
      PAL_RAINBOW: last = IDX_W'(4);
      default:     last = IDX_W'(1);
    endcase
    return last;
  endfunction

  function automatic rgb_t mk(input int unsigned r, input int unsigned g,
                              input int unsigned b);
    rgb_t c;
    c.red   = NODE_W'(r);
    c.green = NODE_W'(g);
    c.blue  = NODE_W'(b);
    return c;
  endfunction

  function automatic rgb_t palette_node(input palette_e pal, input logic [IDX_W-1:0] idx);
    rgb_t c;
    c = mk(0, 0, 0);
    unique case (pal)
      PAL_VIRIDIS, PAL_GRAY: begin
        case (idx)
          4'd0:    c = mk( 68,   1,  84);
          4'd1:    c = mk( 72,  35, 116);
          4'd2:    c = mk( 64,  67, 135);
          4'd3:    c = mk( 52,  94, 141);
          4'd4:    c = mk( 41, 120, 142);
          4'd5:    c = mk( 32, 144, 140);
          4'd6:    c = mk( 34, 168, 132);
          4'd7:    c = mk( 68, 190, 112);
          4'd8:    c = mk(121, 209,  81);
          4'd9:    c = mk(189, 223,  38);
          4'd10:   c = mk(253, 231,  37);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_PLASMA: begin
        case (idx)
          4'd0:    c = mk( 13,   8, 135);
          4'd1:    c = mk( 70,   3, 159);
          4'd2:    c = mk(114,   1, 168);
          4'd3:    c = mk(156,  23, 158);
          4'd4:    c = mk(189,  55, 134);
          4'd5:    c = mk(216,  87, 107);
          4'd6:    c = mk(237, 121,  83);
          4'd7:    c = mk(251, 159,  58);
          4'd8:    c = mk(253, 202,  38);
          4'd9:    c = mk(240, 249,  33);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_INFERNO: begin
        case (idx)
          4'd0:    c = mk(  0,   0,   4);
          4'd1:    c = mk( 31,  12,  72);
          4'd2:    c = mk( 85,  15, 109);
          4'd3:    c = mk(136,  34, 106);
          4'd4:    c = mk(186,  54,  85);
          4'd5:    c = mk(227,  89,  51);
          4'd6:    c = mk(249, 140,  10);
          4'd7:    c = mk(252, 197,  46);
          4'd8:    c = mk(245, 246, 109);
          4'd9:    c = mk(252, 255, 164);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_MAGMA: begin
        case (idx)
          4'd0:    c = mk(  0,   0,   4);
          4'd1:    c = mk( 28,  16,  68);
          4'd2:    c = mk( 79,  18, 123);
          4'd3:    c = mk(129,  37, 129);
          4'd4:    c = mk(181,  54, 122);
          4'd5:    c = mk(227,  89, 106);
          4'd6:    c = mk(251, 136,  97);
          4'd7:    c = mk(254, 189, 130);
          4'd8:    c = mk(252, 233, 178);
          4'd9:    c = mk(251, 252, 191);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_TURBO: begin
        case (idx)
          4'd0:    c = mk( 48,  18,  59);
          4'd1:    c = mk( 70, 134, 251);
          4'd2:    c = mk( 27, 208, 213);
          4'd3:    c = mk( 99, 247,  97);
          4'd4:    c = mk(196, 240,  43);
          4'd5:    c = mk(253, 175,  39);
          4'd6:    c = mk(243,  89,  27);
          4'd7:    c = mk(194,  36,  11);
          4'd8:    c = mk(122,   4,   3);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_CIVIDIS: begin
        case (idx)
          4'd0:    c = mk(  0,  32,  77);
          4'd1:    c = mk( 28,  54, 101);
          4'd2:    c = mk( 63,  75, 114);
          4'd3:    c = mk(100,  96, 121);
          4'd4:    c = mk(138, 119, 124);
          4'd5:    c = mk(178, 145, 121);
          4'd6:    c = mk(217, 175, 107);
          4'd7:    c = mk(245, 210,  83);
          4'd8:    c = mk(255, 234,  70);
          default: c = mk(0, 0, 0);
        endcase
      end
      PAL_RAINBOW: begin
        case (idx)
          4'd0:    c = mk(  0,   0, 255);
          4'd1:    c = mk(  0, 255, 255);
          4'd2:    c = mk(  0, 255,   0);
          4'd3:    c = mk(255, 255,   0);
          4'd4:    c = mk(255,   0,   0);
          default: c = mk(0, 0, 0);
        endcase
      end
      default: c = mk(0, 0, 0);
    endcase
    return c;
  endfunction

endpackage

// File: src/cpll_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpll_front: position decode
// Saturates the fraction, finds the surrounding node pair and the weight.
// ----------------------------------------------------------------------------
module cpll_front #(
  parameter int unsigned FRAC_BITS = cpll_pkg::FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [FRAC_BITS:0]     fraction_i,
  input  cpll_pkg::palette_e     palette_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output cpll_pkg::node_pair_t   pair_o,
  output logic [FRAC_BITS-1:0]   weight_o
);

  localparam int unsigned POS_W = FRAC_BITS + cpll_pkg::IDX_W;

  logic                          valid_q;
  cpll_pkg::node_pair_t          pair_d, pair_q;
  logic [FRAC_BITS-1:0]          weight_d, weight_q;
  logic                          sat;
  logic [FRAC_BITS-1:0]          frac;
  logic [cpll_pkg::IDX_W-1:0]    last;
  logic [cpll_pkg::IDX_W-1:0]    idx;
  logic [POS_W-1:0]              pos;
  cpll_pkg::rgb_t                black, white;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign pair_o  = pair_q;
  assign weight_o = weight_q;

  always_comb begin
    sat   = fraction_i[FRAC_BITS];
    frac  = fraction_i[FRAC_BITS-1:0];
    last  = cpll_pkg::node_last(palette_i);
    pos   = POS_W'(frac) * POS_W'(last);
    idx   = pos[POS_W-1:FRAC_BITS];
    black = cpll_pkg::mk(0, 0, 0);
    white = cpll_pkg::mk(255, 255, 255);
    if (palette_i == cpll_pkg::PAL_GRAY) begin
      if (sat) begin
        pair_d.n0 = white;
        pair_d.n1 = white;
        weight_d  = '0;
      end else begin
        pair_d.n0 = black;
        pair_d.n1 = white;
        weight_d  = frac;
      end
    end else if (sat) begin
      pair_d.n0 = cpll_pkg::palette_node(palette_i, last);
      pair_d.n1 = pair_d.n0;
      weight_d  = '0;
    end else begin
      pair_d.n0 = cpll_pkg::palette_node(palette_i, idx);
      pair_d.n1 = cpll_pkg::palette_node(palette_i, idx + cpll_pkg::IDX_W'(1));
      weight_d  = pos[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      pair_q   <= pair_d;
      weight_q <= weight_d;
    end
  end

endmodule

// File: src/cpll_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpll_queue: decoupling queue
// Small first-in first-out buffer between position decode and blending.
// ----------------------------------------------------------------------------
module cpll_queue #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = cpll_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  logic [WIDTH-1:0] data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr, rd;

  assign ready_o = (cnt_q != CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign wr      = valid_i && ready_o;
  assign rd      = valid_o && ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr && !rd) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd && !wr) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/cpll_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpll_back: channel blend
// Weights the node pair per channel, rounds half up and holds the result.
// ----------------------------------------------------------------------------
module cpll_back #(
  parameter int unsigned FRAC_BITS = cpll_pkg::FRAC_BITS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  cpll_pkg::node_pair_t   pair_i,
  input  logic [FRAC_BITS-1:0]   weight_i,
  output logic                   empty,
  input  logic                   pop,
  output cpll_pkg::rgb_t         rgb_o
);

  localparam int unsigned NW    = cpll_pkg::NODE_W;
  localparam int unsigned P0_W  = NW + FRAC_BITS + 1;
  localparam int unsigned SUM_W = P0_W + 1;

  logic                  s1_valid_q, out_valid_q;
  logic                  en1, en2;
  logic [FRAC_BITS:0]    inv_w;
  logic [P0_W-1:0]       p0_d [3];
  logic [P0_W-1:0]       p1_d [3];
  logic [P0_W-1:0]       p0_q [3];
  logic [P0_W-1:0]       p1_q [3];
  logic [SUM_W-1:0]      sum [3];
  logic [NW-1:0]         n0 [3];
  logic [NW-1:0]         n1 [3];
  cpll_pkg::rgb_t        rgb_d, rgb_q;

  assign en2     = !out_valid_q || pop;
  assign en1     = !s1_valid_q || en2;
  assign ready_o = en1;
  assign empty   = !out_valid_q;
  assign rgb_o   = rgb_q;

  always_comb begin
    n0[0] = pair_i.n0.red;
    n0[1] = pair_i.n0.green;
    n0[2] = pair_i.n0.blue;
    n1[0] = pair_i.n1.red;
    n1[1] = pair_i.n1.green;
    n1[2] = pair_i.n1.blue;
    inv_w = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    inv_w = inv_w - (FRAC_BITS + 1)'(weight_i);
    for (int c = 0; c < 3; c++) begin
      p0_d[c] = P0_W'(n0[c]) * P0_W'(inv_w);
      p1_d[c] = P0_W'(n1[c]) * P0_W'(weight_i);
    end
    for (int c = 0; c < 3; c++) begin
      sum[c] = SUM_W'(p0_q[c]) + SUM_W'(p1_q[c]) + (SUM_W'(1) << (FRAC_BITS - 1));
    end
    rgb_d.red   = sum[0][FRAC_BITS +: NW];
    rgb_d.green = sum[1][FRAC_BITS +: NW];
    rgb_d.blue  = sum[2][FRAC_BITS +: NW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid_q <= valid_i;
      end
      if (en2) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && valid_i) begin
      p0_q <= p0_d;
      p1_q <= p1_d;
    end
    if (en2 && s1_valid_q) begin
      rgb_q <= rgb_d;
    end
  end

endmodule

// File: src/colormap_piecewise_linear_lookup.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// colormap_piecewise_linear_lookup: false-color palette lookup
// Maps an unsigned fixed-point fraction to an RGB color by linear
// interpolation between the nodes of the palette chosen by register.
// ----------------------------------------------------------------------------
// Accepts one fraction per clock while full is low and returns one color per
// fraction in order. A fraction travels through a decode register, a two-entry
// queue, a product register and the output register. Every stage takes a new
// item each clock while results are popped, so the sustained rate is one per
// clock; a held result stalls the stages behind it, and full rises once five
// fractions are in flight. Fractions of one or more saturate to the last node;
// the gray palette is a straight ramp from black to white.
// ----------------------------------------------------------------------------
module colormap_piecewise_linear_lookup #(
  parameter int unsigned FRAC_BITS = cpll_pkg::FRAC_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cpll_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpll_pkg::DATA_W-1:0]  pwdata,
  output logic [cpll_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         push,
  output logic                         full,
  input  logic [FRAC_BITS:0]           fraction_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [7:0]                   red_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   blue_o
);

  localparam int unsigned ITEM_W = cpll_pkg::PAIR_W + FRAC_BITS;

  cpll_pkg::palette_e     palette_q;
  logic                   reg_hit;
  logic                   fe_ready, fe_valid, q_ready, q_valid, be_ready;
  cpll_pkg::node_pair_t   fe_pair, be_pair;
  logic [FRAC_BITS-1:0]   fe_weight, be_weight;
  logic [ITEM_W-1:0]      q_out;
  cpll_pkg::rgb_t         rgb;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[cpll_pkg::ADDR_W-1] == cpll_pkg::REG_PALETTE_SEL);
  assign prdata  = reg_hit ? cpll_pkg::DATA_W'(palette_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_q <= cpll_pkg::PAL_VIRIDIS;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      palette_q <= cpll_pkg::palette_e'(pwdata[2:0]);
    end
  end

  assign full = !fe_ready;

  cpll_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (push),
    .ready_o    (fe_ready),
    .fraction_i (fraction_i),
    .palette_i  (palette_q),
    .valid_o    (fe_valid),
    .ready_i    (q_ready),
    .pair_o     (fe_pair),
    .weight_o   (fe_weight)
  );

  cpll_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (cpll_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .ready_o (q_ready),
    .data_i  ({fe_pair, fe_weight}),
    .valid_o (q_valid),
    .ready_i (be_ready),
    .data_o  (q_out)
  );

  assign be_pair   = cpll_pkg::node_pair_t'(q_out[ITEM_W-1:FRAC_BITS]);
  assign be_weight = q_out[FRAC_BITS-1:0];

  cpll_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .ready_o  (be_ready),
    .pair_i   (be_pair),
    .weight_i (be_weight),
    .empty    (empty),
    .pop      (pop),
    .rgb_o    (rgb)
  );

  assign red_o   = rgb.red;
  assign green_o = rgb.green;
  assign blue_o  = rgb.blue;

endmodule
